@@ hdl/wav_pcm_mono_stream_parser_defines.svh @@
// assertion macros for the wav pcm mono stream parser
// expects signals named clk and rst_n in the scope of use
`ifndef WAV_PCM_MONO_STREAM_PARSER_DEFINES_SVH
`define WAV_PCM_MONO_STREAM_PARSER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define WPM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define WPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/wpm_pkg.sv @@
// shared types and constants of the wav pcm mono stream parser
// no dependencies
`default_nettype none

package wpm_pkg;

    // parse phases
    localparam logic [2:0] PH_RIFF  = 3'd0;
    localparam logic [2:0] PH_SFMT  = 3'd1;
    localparam logic [2:0] PH_SKIPF = 3'd2;
    localparam logic [2:0] PH_FMT   = 3'd3;
    localparam logic [2:0] PH_SDATA = 3'd4;
    localparam logic [2:0] PH_SKIPD = 3'd5;
    localparam logic [2:0] PH_DATA  = 3'd6;
    localparam logic [2:0] PH_DONE  = 3'd7;

    // status codes
    localparam logic [2:0] ST_HEADER    = 3'd0;
    localparam logic [2:0] ST_DATA      = 3'd1;
    localparam logic [2:0] ST_DONE      = 3'd2;
    localparam logic [2:0] ST_BAD_RIFF  = 3'd3;
    localparam logic [2:0] ST_NOT_PCM   = 3'd4;
    localparam logic [2:0] ST_NOT_MONO  = 3'd5;
    localparam logic [2:0] ST_BAD_RATE  = 3'd6;
    localparam logic [2:0] ST_TRUNCATED = 3'd7;

    // little-endian tags as they sit in the shift word
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] FMT_SIZE = 32'd16;
    localparam logic [31:0] FMT_TAIL = 32'd8;

    localparam logic [31:0] RATE_RESET = 32'd44100;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } in_word_t;

    typedef struct packed {
        logic               sample_valid;
        logic signed [15:0] sample;
        logic [2:0]         status;
        logic [31:0]        data_left;
    } out_word_t;

    typedef struct packed {
        logic     valid;
        in_word_t word;
    } in_stage_t;

endpackage

`default_nettype wire

@@ hdl/wav_pcm_mono_stream_parser.sv @@
// top level of the wav pcm mono stream parser
// depends on wpm_pkg, wpm_in_reg, wpm_parser and the defines header
//
// usage
//   in channel: one file word per handshake (in_valid/in_ready), holding the
//   next byte of the file and a flag that marks the last byte
//   out channel: one result word per input word (out_valid/out_ready), with
//   a sample flag, the signed sample, the parse status and the bytes left in
//   the data chunk
//   cfg channel: cfg_data sets the sample rate the fmt chunk must declare;
//   cfg_ready is always high, write only while the block is idle
// timing
//   a taken word moves from the input register into the result register once
//   it is free or being read; one word per cycle while out_ready is high, as
//   the whole step for a byte is one pass of logic between the two registers
// reset
//   rst_n clears both stages, returns the walk to the riff tag and loads
//   the rate register with 44100
// stalls
//   with out_ready low the result holds; the input register still takes one
//   more word, then in_ready drops until the result is taken
`default_nettype none
`include "wav_pcm_mono_stream_parser_defines.svh"

module wav_pcm_mono_stream_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire wpm_pkg::in_word_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output wpm_pkg::out_word_t     out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [31:0]       cfg_data
);

    // rate register, written straight from the cfg channel
    logic [31:0] rate_reg;

    // word waiting in the input register, and its move into the parser
    wpm_pkg::in_stage_t stage;
    logic               take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= wpm_pkg::RATE_RESET;
        end
        else if (cfg_valid)
        begin
            rate_reg <= cfg_data;
        end
    end

    wpm_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .take     (take),
        .stage    (stage)
    );

    wpm_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .expected_rate (rate_reg),
        .stage         (stage),
        .take          (take),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data)
    );

    // a sample only comes out while data is flowing, done or cut short
    `WPM_ASSERT_NOW(a_sample_in_data, out_valid && out_data.sample_valid, out_data.status == wpm_pkg::ST_DATA || out_data.status == wpm_pkg::ST_DONE || out_data.status == wpm_pkg::ST_TRUNCATED, "sample outside data chunk")

    // no sample means a zero sample field
    `WPM_ASSERT_NOW(a_sample_zero, out_valid && !out_data.sample_valid, out_data.sample == 16'sd0, "stale sample value")

    // a waiting input word reaches an empty result register at once
    `WPM_ASSERT_NEXT(a_no_loss, stage.valid && !out_valid, out_valid, "input word lost")

endmodule

`default_nettype wire

@@ hdl/wpm_in_reg.sv @@
// input register of the wav pcm mono stream parser
// depends on wpm_pkg
`default_nettype none

module wpm_in_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire wpm_pkg::in_word_t in_data,
    input  wire logic             take,
    output wpm_pkg::in_stage_t    stage
);

    logic              valid_reg;
    logic              valid_next;
    wpm_pkg::in_word_t word_reg;

    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_data;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.word  = word_reg;

endmodule

`default_nettype wire

@@ hdl/wpm_parser.sv @@
// header walk, sample pairing and result register of the parser
// depends on wpm_pkg
`default_nettype none

module wpm_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [31:0]       expected_rate,
    input  wire wpm_pkg::in_stage_t stage,
    output logic                   take,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output wpm_pkg::out_word_t     out_data
);

    logic [2:0]  phase_reg,   phase_next;
    logic [3:0]  idx_reg,     idx_next;
    logic [31:0] word_reg,    word_next;
    logic        size_ok_reg, size_ok_next;
    logic [31:0] skip_reg,    skip_next;
    logic [31:0] data_reg,    data_next;
    logic [8:0]  hold_reg,    hold_next;
    logic [2:0]  err_reg,     err_next;
    logic        out_valid_reg, out_valid_next;
    wpm_pkg::out_word_t out_data_reg, res;

    logic [7:0]  b;
    logic [31:0] word;
    logic [31:0] skip_dec;
    logic [31:0] data_dec;
    logic        emit;
    logic [15:0] smp;
    logic [2:0]  status;

    assign take = stage.valid && (!out_valid_reg || out_ready);
    assign b    = stage.word.file_byte;
    assign word = {b, word_reg[31:8]};
    assign skip_dec = (skip_reg != 32'd0) ? skip_reg - 32'd1 : skip_reg;
    assign data_dec = (data_reg != 32'd0) ? data_reg - 32'd1 : data_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        word_next    = word_reg;
        size_ok_next = size_ok_reg;
        skip_next    = skip_reg;
        data_next    = data_reg;
        hold_next    = hold_reg;
        err_next     = err_reg;
        emit         = 1'b0;
        smp          = 16'd0;
        if (err_reg == wpm_pkg::ST_HEADER && phase_reg != wpm_pkg::PH_DONE)
        begin
            word_next = word;
            unique case (phase_reg)
                wpm_pkg::PH_RIFF:
                begin
                    if (idx_reg == 4'd3 && word != wpm_pkg::TAG_RIFF)
                    begin
                        err_next = wpm_pkg::ST_BAD_RIFF;
                    end
                    else if (idx_reg >= 4'd11)
                    begin
                        if (word != wpm_pkg::TAG_WAVE)
                        begin
                            err_next = wpm_pkg::ST_BAD_RIFF;
                        end
                        else
                        begin
                            phase_next = wpm_pkg::PH_SFMT;
                            idx_next   = 4'd0;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
                wpm_pkg::PH_SFMT:
                begin
                    if (idx_reg == 4'd3 && word == wpm_pkg::TAG_FMT)
                    begin
                        phase_next = wpm_pkg::PH_FMT;
                        idx_next   = 4'd0;
                    end
                    else if (idx_reg >= 4'd7)
                    begin
                        // unknown chunk, zero size keeps searching
                        skip_next = word;
                        idx_next  = 4'd0;
                        if (word != 32'd0)
                        begin
                            phase_next = wpm_pkg::PH_SKIPF;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
                wpm_pkg::PH_SKIPF, wpm_pkg::PH_SKIPD:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 32'd0)
                    begin
                        phase_next = (phase_reg == wpm_pkg::PH_SKIPF) ?
                                     wpm_pkg::PH_SFMT : wpm_pkg::PH_SDATA;
                        idx_next   = 4'd0;
                    end
                end
                wpm_pkg::PH_FMT:
                begin
                    idx_next = idx_reg + 4'd1;
                    if (idx_reg == 4'd3)
                    begin
                        size_ok_next = (word == wpm_pkg::FMT_SIZE);
                    end
                    else if (idx_reg == 4'd5)
                    begin
                        if (word[31:16] != 16'd1 || !size_ok_reg)
                        begin
                            err_next = wpm_pkg::ST_NOT_PCM;
                        end
                    end
                    else if (idx_reg == 4'd7)
                    begin
                        if (word[31:16] != 16'd1)
                        begin
                            err_next = wpm_pkg::ST_NOT_MONO;
                        end
                    end
                    else if (idx_reg >= 4'd11)
                    begin
                        idx_next = idx_reg;
                        if (word != expected_rate)
                        begin
                            err_next = wpm_pkg::ST_BAD_RATE;
                        end
                        else
                        begin
                            // skip byte rate, block align and bit depth
                            skip_next  = wpm_pkg::FMT_TAIL;
                            idx_next   = 4'd0;
                            phase_next = wpm_pkg::PH_SKIPD;
                        end
                    end
                end
                wpm_pkg::PH_SDATA:
                begin
                    if (idx_reg == 4'd3)
                    begin
                        idx_next = (word == wpm_pkg::TAG_DATA) ? 4'd8 : 4'd4;
                    end
                    else if (idx_reg == 4'd7)
                    begin
                        skip_next = word;
                        idx_next  = 4'd0;
                        if (word != 32'd0)
                        begin
                            phase_next = wpm_pkg::PH_SKIPD;
                        end
                    end
                    else if (idx_reg >= 4'd11)
                    begin
                        data_next  = word;
                        hold_next  = 9'd0;
                        idx_next   = 4'd0;
                        phase_next = (word != 32'd0) ? wpm_pkg::PH_DATA : wpm_pkg::PH_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
                wpm_pkg::PH_DATA:
                begin
                    data_next = data_dec;
                    if (hold_reg[8])
                    begin
                        emit      = 1'b1;
                        smp       = {b, hold_reg[7:0]};
                        hold_next = 9'd0;
                    end
                    else
                    begin
                        hold_next = {1'b1, b};
                    end
                    // an odd last byte is dropped
                    if (data_dec == 32'd0)
                    begin
                        phase_next = wpm_pkg::PH_DONE;
                        hold_next  = 9'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (stage.word.end_of_file && err_next == wpm_pkg::ST_HEADER &&
            phase_next != wpm_pkg::PH_DONE)
        begin
            err_next = wpm_pkg::ST_TRUNCATED;
        end
    end

    always_comb
    begin
        if (err_next != wpm_pkg::ST_HEADER)
        begin
            status = err_next;
        end
        else if (phase_next == wpm_pkg::PH_DATA)
        begin
            status = wpm_pkg::ST_DATA;
        end
        else if (phase_next == wpm_pkg::PH_DONE)
        begin
            status = wpm_pkg::ST_DONE;
        end
        else
        begin
            status = wpm_pkg::ST_HEADER;
        end
    end

    always_comb
    begin
        res.sample_valid = emit;
        res.sample       = smp;
        res.status       = status;
        res.data_left    = data_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= wpm_pkg::PH_RIFF;
            idx_reg       <= 4'd0;
            word_reg      <= 32'd0;
            size_ok_reg   <= 1'b0;
            skip_reg      <= 32'd0;
            data_reg      <= 32'd0;
            hold_reg      <= 9'd0;
            err_reg       <= wpm_pkg::ST_HEADER;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg   <= phase_next;
                idx_reg     <= idx_next;
                word_reg    <= word_next;
                size_ok_reg <= size_ok_next;
                skip_reg    <= skip_next;
                data_reg    <= data_next;
                hold_reg    <= hold_next;
                err_reg     <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ tb/wav_pcm_mono_stream_parser_tb.sv @@
// self-checking testbench for wav_pcm_mono_stream_parser: one random wav file per run,
// byte words in, one result word per byte out, each result compared with a bit-true predictor
// depends on wpm_pkg and the rtl of the block, nothing else
module wav_pcm_mono_stream_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // longest run of cycles with no handshake on any channel before giving up
    localparam int WATCHDOG_LIMIT = 1000;
    // long receiver hold-off so the two stages fill and in_ready drops
    localparam int HOLD_OFF_CYCLES = 160;
    localparam int REPORT_LIMIT = 10;
    // first data bytes: samples 16'h8000, 16'h7fff, 16'hffff, 16'h0000, low byte first
    localparam logic [63:0] EDGE_BYTES = 64'h0000_FFFF_7FFF_8000;

    // shape of the file sent in this run, picked by the seed
    typedef enum int {
        FILE_GOOD,
        FILE_CUT_DATA,
        FILE_EMPTY_DATA,
        FILE_BAD_TAG,
        FILE_BAD_SIZE,
        FILE_BAD_FORMAT,
        FILE_STEREO,
        FILE_BAD_RATE,
        FILE_CUT_HEADER
    } file_kind_t;

    // predictor state of the parser plus the queue of results still owed by the block
    class parse_scoreboard;
        logic [31:0] rate = wpm_pkg::RATE_RESET;
        logic [2:0]  walk = wpm_pkg::PH_RIFF;
        logic [3:0]  idx = '0;
        logic [31:0] shift = '0;
        logic        size_ok = 1'b0;
        logic [31:0] skip_left = '0;
        logic [31:0] data_left = '0;
        logic [8:0]  held = '0;
        logic [2:0]  err = '0;
        wpm_pkg::out_word_t awaited_results[$];
        int          failures = 0;
        int          results_seen = 0;

        function void begin_skip(logic [31:0] len, logic [2:0] skip_walk);
            skip_left = len;
            idx = '0;
            if (len != 0)
                walk = skip_walk;
        endfunction

        function void skip_step(logic [2:0] back_walk);
            if (skip_left != 0)
                skip_left--;
            if (skip_left == 0)
            begin
                walk = back_walk;
                idx = '0;
            end
        endfunction

        // one byte through the header walk or the data pairing, returns 1 on a finished sample
        function bit parse_byte(logic [7:0] b, output logic [15:0] smp);
            logic [3:0]  i;
            logic [31:0] w;
            bit          emit;
            i = idx;
            w = {b, shift[31:8]};
            emit = 1'b0;
            smp = '0;
            shift = w;
            case (walk)
                wpm_pkg::PH_RIFF:
                    if (i == 4'd3 && w != wpm_pkg::TAG_RIFF)
                        err = wpm_pkg::ST_BAD_RIFF;
                    else if (i >= 4'd11)
                    begin
                        if (w != wpm_pkg::TAG_WAVE)
                            err = wpm_pkg::ST_BAD_RIFF;
                        else
                        begin
                            walk = wpm_pkg::PH_SFMT;
                            idx = '0;
                        end
                    end
                    else
                        idx = i + 4'd1;
                wpm_pkg::PH_SFMT:
                    if (i == 4'd3 && w == wpm_pkg::TAG_FMT)
                    begin
                        walk = wpm_pkg::PH_FMT;
                        idx = '0;
                    end
                    else if (i >= 4'd7)
                        begin_skip(w, wpm_pkg::PH_SKIPF);
                    else
                        idx = i + 4'd1;
                wpm_pkg::PH_SKIPF:
                    skip_step(wpm_pkg::PH_SFMT);
                wpm_pkg::PH_FMT:
                begin
                    if (i == 4'd3)
                        size_ok = (w == wpm_pkg::FMT_SIZE);
                    else if (i == 4'd5)
                    begin
                        if (w[31:16] != 16'd1 || !size_ok)
                            err = wpm_pkg::ST_NOT_PCM;
                    end
                    else if (i == 4'd7)
                    begin
                        if (w[31:16] != 16'd1)
                            err = wpm_pkg::ST_NOT_MONO;
                    end
                    if (i >= 4'd11)
                    begin
                        if (w != rate)
                            err = wpm_pkg::ST_BAD_RATE;
                        else
                            begin_skip(wpm_pkg::FMT_TAIL, wpm_pkg::PH_SKIPD);
                    end
                    else
                        idx = i + 4'd1;
                end
                wpm_pkg::PH_SDATA:
                    if (i == 4'd3)
                        idx = (w == wpm_pkg::TAG_DATA) ? 4'd8 : 4'd4;
                    else if (i == 4'd7)
                        begin_skip(w, wpm_pkg::PH_SKIPD);
                    else if (i >= 4'd11)
                    begin
                        data_left = w;
                        held = '0;
                        idx = '0;
                        walk = (w != 0) ? wpm_pkg::PH_DATA : wpm_pkg::PH_DONE;
                    end
                    else
                        idx = i + 4'd1;
                wpm_pkg::PH_SKIPD:
                    skip_step(wpm_pkg::PH_SDATA);
                wpm_pkg::PH_DATA:
                begin
                    if (data_left != 0)
                        data_left--;
                    if (held[8])
                    begin
                        emit = 1'b1;
                        smp = {b, held[7:0]};
                        held = '0;
                    end
                    else
                        held = {1'b1, b};
                    if (data_left == 0)
                        walk = wpm_pkg::PH_DONE;
                end
                default: ;
            endcase
            return emit;
        endfunction

        function void note_byte(wpm_pkg::in_word_t w);
            wpm_pkg::out_word_t e;
            logic [15:0]        smp;
            bit                 emitted;
            emitted = 1'b0;
            smp = '0;
            if (err == 0 && walk != wpm_pkg::PH_DONE)
            begin
                emitted = parse_byte(w.file_byte, smp);
                if (!emitted && walk == wpm_pkg::PH_DONE)
                    held = '0;
            end
            if (w.end_of_file && err == 0 && walk != wpm_pkg::PH_DONE)
                err = wpm_pkg::ST_TRUNCATED;
            e.sample_valid = emitted;
            e.sample = smp;
            if (err != 0)
                e.status = err;
            else if (walk == wpm_pkg::PH_DATA)
                e.status = wpm_pkg::ST_DATA;
            else if (walk == wpm_pkg::PH_DONE)
                e.status = wpm_pkg::ST_DONE;
            else
                e.status = wpm_pkg::ST_HEADER;
            e.data_left = data_left;
            awaited_results.push_back(e);
        endfunction

        // reports list valid/sample/status/left
        function void check_result(wpm_pkg::out_word_t got);
            wpm_pkg::out_word_t e;
            results_seen++;
            if (awaited_results.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("result %0d unexpected: got %0b/%0d/%0d/%0d",
                             results_seen, got.sample_valid, got.sample, got.status,
                             got.data_left);
                return;
            end
            e = awaited_results.pop_front();
            if (got.sample_valid !== e.sample_valid || got.sample !== e.sample ||
                got.status !== e.status || got.data_left !== e.data_left)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("result %0d: expected %0b/%0d/%0d/%0d, got %0b/%0d/%0d/%0d",
                             results_seen, e.sample_valid, e.sample, e.status, e.data_left,
                             got.sample_valid, got.sample, got.status, got.data_left);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    wpm_pkg::in_word_t  in_data;
    logic               out_valid;
    logic               out_ready;
    wpm_pkg::out_word_t out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [31:0]        cfg_data;

    parse_scoreboard book = new;

    // sender bookkeeping
    int  bytes_sent = 0;
    int  eof_at = -1;        // byte number that carries a forced end of file, -1 for none
    bit  send_steady = 1'b0; // a stretch with no sender gaps
    bit  hold_off_req = 1'b0;

    wav_pcm_mono_stream_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // offer one file byte after a random gap, hold it until taken, then log it
    // valid is only lowered when a gap follows, so back-to-back words keep it high
    task automatic send_byte(input logic [7:0] b, input bit last);
        int                gap;
        wpm_pkg::in_word_t w;
        if (bytes_sent % 64 == 0)
            send_steady = ($urandom_range(0, 2) == 0);
        gap = send_steady ? 0 : $urandom_range(0, 15);
        w.file_byte = b;
        w.end_of_file = last || (bytes_sent == eof_at);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do @(posedge clk); while (!in_ready);
        book.note_byte(w);
        bytes_sent++;
    endtask

    // four bytes, least significant first; tags in the package are already in that order
    task automatic send_le32(input logic [31:0] v);
        for (int k = 0; k < 4; k++)
            send_byte(v[8*k +: 8], 1'b0);
    endtask

    // chunk header plus random body
    task automatic send_chunk(input logic [31:0] tag, input logic [31:0] len);
        send_le32(tag);
        send_le32(len);
        repeat (len) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // rate register only changes with the block drained; every byte yields a result,
    // so an empty queue means nothing is left in flight
    task automatic write_rate(input logic [31:0] v);
        in_valid <= 1'b0;
        while (book.awaited_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        book.rate = v;
        cfg_valid <= 1'b0;
    endtask

    // chunk tag that is neither fmt nor data
    function automatic logic [31:0] random_tag();
        logic [31:0] t;
        do t = $urandom; while (t == wpm_pkg::TAG_FMT || t == wpm_pkg::TAG_DATA);
        return t;
    endfunction

    // mostly short unknown chunks, now and then a longer one
    function automatic logic [31:0] junk_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    endfunction

    // receiver: random stalls per word, steady stretches, and one long hold-off on request
    initial
    begin
        int stall;
        bit steady;
        stall = 0;
        steady = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                book.check_result(out_data);
                if (book.results_seen % 64 == 0)
                    steady = ($urandom_range(0, 2) == 0);
                stall = steady ? 0 : $urandom_range(0, 15);
            end
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog: any handshake on any channel counts as progress
    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("wav_pcm_mono_stream_parser_tb: FAIL");
        $finish;
    end

    // main sequence: one file per run since errors and data done are sticky until reset
    initial
    begin
        file_kind_t  kind;
        int          pick;
        int          n;
        bit          last_eof;
        logic [31:0] riff_tag;
        logic [31:0] wave_tag;
        logic [31:0] fmt_size;
        logic [15:0] fmt_code;
        logic [15:0] chans;
        logic [31:0] declared_rate;
        logic [31:0] data_size;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;

        // mostly well-formed files; the rest: each header fault, truncation, empty data
        pick = $urandom_range(0, 19);
        case (pick)
            11, 12:  kind = FILE_CUT_DATA;
            13:      kind = FILE_EMPTY_DATA;
            14:      kind = FILE_BAD_TAG;
            15:      kind = FILE_BAD_SIZE;
            16:      kind = FILE_BAD_FORMAT;
            17:      kind = FILE_STEREO;
            18:      kind = FILE_BAD_RATE;
            19:      kind = FILE_CUT_HEADER;
            default: kind = FILE_GOOD;
        endcase

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // first rate write straight after reset, an extreme or a random value
        case ($urandom_range(0, 2))
            0:       write_rate(32'd0);
            1:       write_rate(32'hFFFF_FFFF);
            default: write_rate($urandom);
        endcase

        // riff header, one tag broken on a single bit for the bad tag file
        riff_tag = wpm_pkg::TAG_RIFF;
        wave_tag = wpm_pkg::TAG_WAVE;
        if (kind == FILE_BAD_TAG)
        begin
            if ($urandom_range(0, 1) == 0)
                riff_tag ^= 32'h1 << $urandom_range(0, 31);
            else
                wave_tag ^= 32'h1 << $urandom_range(0, 31);
        end
        if (kind == FILE_CUT_HEADER)
            eof_at = $urandom_range(0, 60);
        send_le32(riff_tag);
        send_le32($urandom);
        send_le32(wave_tag);

        // unknown chunks ahead of fmt: an empty one, a data chunk that must be skipped
        // here, then a few random ones
        send_chunk(random_tag(), 32'd0);
        send_chunk(wpm_pkg::TAG_DATA, $urandom_range(1, 6));
        repeat ($urandom_range(0, 3)) send_chunk(random_tag(), junk_len());

        // rate that the fmt chunk declares, loaded while the walk is between chunks
        case ($urandom_range(0, 4))
            0:       declared_rate = wpm_pkg::RATE_RESET;
            1:       declared_rate = 32'd0;
            2:       declared_rate = 32'hFFFF_FFFF;
            3:       declared_rate = 32'd8000;
            default: declared_rate = $urandom;
        endcase
        write_rate(declared_rate);

        // fmt chunk with the one fault this file carries, if any
        fmt_size = wpm_pkg::FMT_SIZE;
        fmt_code = 16'd1;
        chans = 16'd1;
        if (kind == FILE_BAD_SIZE)
        begin
            if ($urandom_range(0, 1) == 0)
                fmt_size = $urandom_range(0, 15);
            else
                fmt_size = $urandom_range(17, 32'hFFFF_FFFF);
        end
        if (kind == FILE_BAD_FORMAT)
            do fmt_code = 16'($urandom); while (fmt_code == 16'd1);
        if (kind == FILE_STEREO)
            do chans = 16'($urandom); while (chans == 16'd1);
        send_le32(wpm_pkg::TAG_FMT);
        send_le32(fmt_size);
        send_le32({chans, fmt_code});
        send_le32((kind == FILE_BAD_RATE) ? declared_rate ^ (32'h1 << $urandom_range(0, 31))
                                          : declared_rate);
        // byte rate, block align and bit depth are skipped by the block
        send_le32($urandom);
        send_le32($urandom);

        // unknown chunks ahead of data: an empty one, a second fmt that now counts as unknown
        send_chunk(random_tag(), 32'd0);
        send_chunk(wpm_pkg::TAG_FMT, $urandom_range(1, 6));
        repeat ($urandom_range(0, 2)) send_chunk(random_tag(), junk_len());

        // data chunk size and how many bytes follow; faulty files still carry a full body
        case (kind)
            FILE_GOOD:
            begin
                n = $urandom_range(1450, 1550);
                data_size = 32'(n);
                last_eof = 1'($urandom_range(0, 1));
            end
            FILE_CUT_DATA:
            begin
                n = $urandom_range(1450, 1550);
                data_size = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF
                                                        : ($urandom | 32'h8000_0000);
                last_eof = 1'b1;
            end
            FILE_EMPTY_DATA:
            begin
                n = $urandom_range(1450, 1550);
                data_size = 32'd0;
                last_eof = 1'($urandom_range(0, 1));
            end
            default:
            begin
                n = $urandom_range(1450, 1550);
                data_size = 32'(n);
                last_eof = 1'($urandom_range(0, 1));
            end
        endcase
        send_le32(wpm_pkg::TAG_DATA);
        // receiver stalls for a long stretch while the sender keeps offering
        hold_off_req = 1'b1;
        send_le32(data_size);

        // data bytes: edge samples first, then random; the rate changes mid-stream to
        // both extremes, which must not disturb sample pairing
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 3)
                write_rate(32'd0);
            else if (i == 2 * n / 3)
                write_rate(32'hFFFF_FFFF);
            send_byte((i < 8) ? EDGE_BYTES[8*i +: 8] : 8'($urandom_range(0, 255)),
                      (i == n - 1) && last_eof);
        end

        // trailing bytes land on a finished or failed walk and must change nothing
        repeat (4) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        in_valid <= 1'b0;

        while (book.awaited_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (book.failures == 0 && book.awaited_results.size() == 0)
            $display("wav_pcm_mono_stream_parser_tb: PASS");
        else
            $display("wav_pcm_mono_stream_parser_tb: FAIL");
        $finish;
    end

endmodule
